[rtl/profile_matrix_sequence_score_core_defines.svh]
// Assertion macros used by the top RTL file of the scoring core
`ifndef PROFILE_MATRIX_SEQUENCE_SCORE_CORE_DEFINES_SVH
`define PROFILE_MATRIX_SEQUENCE_SCORE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PMSS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PMSS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pmss_pkg.sv]
// Types, constants and helpers of the scoring core
`timescale 1ns / 1ps

package pmss_pkg;

  // field widths
  localparam int ALPHABET   = 26;
  localparam int ACTION_W   = 2;
  localparam int POS_W      = 7;
  localparam int LETTER_W   = 5;
  localparam int WEIGHT_W   = 16;
  localparam int COUNT_W    = 16;
  localparam int SUM_W      = 23;
  localparam int PCT_W      = 15;
  localparam int OFFSET_W   = 7;
  localparam int NUMER_W    = SUM_W + PCT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // limits
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [PCT_W-1:0]   PCT_MAX   = 15'd25600;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESIDUE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXTEND_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_X      = 2'd2;

  // letters left out of the best weight
  localparam logic [LETTER_W-1:0] LETTER_B = 5'd1;
  localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_O = 5'd14;
  localparam logic [LETTER_W-1:0] LETTER_U = 5'd20;
  localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
  localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;

  // one matrix row: ALPHABET weights plus the row's best weight on top
  typedef logic [ALPHABET:0][WEIGHT_W-1:0] row_t;
  localparam logic [LETTER_W-1:0] BEST_SLOT = 5'(ALPHABET);

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic is_excluded(input logic [LETTER_W-1:0] l);
    return l inside {LETTER_B, LETTER_J, LETTER_O, LETTER_U, LETTER_X, LETTER_Z};
  endfunction

endpackage

[rtl/pmss_chan_if.sv]
// Valid/ready channel interfaces for residue input and score output
`timescale 1ns / 1ps

interface pmss_in_if;
  import pmss_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [POS_W-1:0]    position;
  logic [LETTER_W-1:0] letter;
  logic [WEIGHT_W-1:0] weight;
  logic                last;

  modport source (output valid, action, position, letter, weight, last, input ready);
  modport sink   (input valid, action, position, letter, weight, last, output ready);
endinterface

interface pmss_out_if;
  import pmss_pkg::*;

  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] percent_score;
  logic             too_short;
  logic             zero_best;

  modport source (output valid, percent_score, too_short, zero_best, input ready);
  modport sink   (input valid, percent_score, too_short, zero_best, output ready);
endinterface

[rtl/pmss_ram.sv]
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module pmss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/pmss_div.sv]
// Restoring divider, one quotient bit per cycle, quotient known to fit PCT_W bits
`timescale 1ns / 1ps

module pmss_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pmss_pkg::NUMER_W-1:0] numer,
  input  logic [pmss_pkg::SUM_W-1:0]   denom,
  output logic [pmss_pkg::PCT_W-1:0]   quot,
  output pmss_pkg::div_stat_t          stat
);
  import pmss_pkg::*;

  localparam int STEP_W = $clog2(PCT_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  denom_r, denom_nxt;
  logic [PCT_W-1:0]  lo_r, lo_nxt;

  logic [SUM_W:0] trial;
  logic [SUM_W:0] diff;
  logic           fits;

  // shared subtract/compare: shift in next dividend bit, try the divisor
  assign trial = {rem_r, lo_r[PCT_W-1]};
  assign diff  = trial - {1'b0, denom_r};
  assign fits  = trial >= {1'b0, denom_r};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    denom_nxt = denom_r;
    lo_nxt    = lo_r;
    if (start) begin
      // upper bits are below the divisor, so only PCT_W steps remain
      busy_nxt  = 1'b1;
      step_nxt  = '0;
      rem_nxt   = numer[NUMER_W-1:PCT_W];
      lo_nxt    = numer[PCT_W-1:0];
      denom_nxt = denom;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      lo_nxt   = {lo_r[PCT_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(PCT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    lo_r    <= lo_nxt;
    denom_r <= denom_nxt;
  end

  assign quot      = lo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/profile_matrix_sequence_score_core.sv]
// Position-specific weight matrix scorer: matrix load, residue scoring, percent result
//
//   channel   dir  beat contents                                  handshake
//   in_ch     in   action, position, letter, weight, last         valid/ready
//   out_ch    out  percent_score, too_short, zero_best            valid/ready
//   cfg_*     in   cfg_index, cfg_data                            cfg_we, no stall
//
// Residue: accept plus one matrix row read. Weight write: row read, 26-step max scan
// on one comparator, row write back. Clear: one row zeroed per cycle. Last residue:
// adds the flag checks and, when score is below best, the 15-step divider. After reset
// a clear of all REF_LENGTH rows runs before in_ch.ready rises. A held result does
// not block input; only the next result waits for out_ch.
`timescale 1ns / 1ps
`include "profile_matrix_sequence_score_core_defines.svh"

module profile_matrix_sequence_score_core #(
  parameter int REF_LENGTH = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pmss_in_if.sink                           in_ch,
  pmss_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [pmss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmss_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pmss_pkg::*;

  localparam int ROW_AW = $clog2(REF_LENGTH);
  localparam int CALC_W = COUNT_W + 1;

  // sequencer states
  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_WR_READ   = 4'd2;
  localparam logic [3:0] ST_WR_SCAN   = 4'd3;
  localparam logic [3:0] ST_WR_STORE  = 4'd4;
  localparam logic [3:0] ST_RES_ACC   = 4'd5;
  localparam logic [3:0] ST_FINISH    = 4'd6;
  localparam logic [3:0] ST_DIV_START = 4'd7;
  localparam logic [3:0] ST_DIV_WAIT  = 4'd8;
  localparam logic [3:0] ST_EMIT      = 4'd9;

  // control state
  logic [3:0]          state_r, state_nxt;
  logic [ROW_AW-1:0]   clr_row_r, clr_row_nxt;
  logic [LETTER_W-1:0] scan_r, scan_nxt;
  logic                extend_r, offset_we, extend_we, count_x_we;
  logic [OFFSET_W-1:0] offset_r;
  logic                count_x_r;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]    score_r, score_nxt;
  logic [SUM_W-1:0]    best_r, best_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload state
  logic [ROW_AW-1:0]   wr_row_r, wr_row_nxt;
  logic [LETTER_W-1:0] letter_r, letter_nxt;
  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic                use_r, use_nxt;
  logic                last_r, last_nxt;
  row_t                row_r, row_nxt;
  logic [WEIGHT_W-1:0] top_r, top_nxt;
  logic [NUMER_W-1:0]  prod_r, prod_nxt;
  logic                short_r, short_nxt;
  logic                zero_r, zero_nxt;
  logic                use_div_r, use_div_nxt;
  logic [PCT_W-1:0]    pct_pre_r, pct_pre_nxt;
  logic [PCT_W-1:0]    out_pct_r, out_pct_nxt;
  logic                out_short_r, out_short_nxt;
  logic                out_zero_r, out_zero_nxt;

  // datapath wiring
  logic                in_acc;
  logic                emit_go;
  logic [CALC_W-1:0]   pos_sum, pos_diff;
  logic                residue_aligned;
  logic                residue_used;
  logic [ROW_AW-1:0]   residue_row;
  logic                write_ok;
  logic                mem_wr_en, mem_rd_en;
  logic [ROW_AW-1:0]   mem_wr_addr, mem_rd_addr;
  row_t                mem_wr_row, mem_rd_row;
  logic [$bits(row_t)-1:0] mem_wr_data, mem_rd_data;
  logic [WEIGHT_W-1:0] res_weight;
  logic [SUM_W:0]      score_add, best_add;
  logic                div_start;
  logic [PCT_W-1:0]    div_quot;
  div_stat_t           div_stat;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == ST_IDLE);

  // configuration writes
  assign extend_we  = cfg_we && (cfg_index == REG_EXTEND_MODE);
  assign offset_we  = cfg_we && (cfg_index == REG_ALIGN_OFFSET);
  assign count_x_we = cfg_we && (cfg_index == REG_COUNT_X);

  // residue alignment to a matrix row
  assign pos_sum  = CALC_W'(count_r) + CALC_W'(offset_r);
  assign pos_diff = CALC_W'(count_r) - CALC_W'(offset_r);

  always_comb begin
    if (!extend_r) begin
      residue_aligned = pos_sum < CALC_W'(REF_LENGTH);
      residue_row     = pos_sum[ROW_AW-1:0];
    end else begin
      residue_aligned = (count_r >= COUNT_W'(offset_r)) && (pos_diff < CALC_W'(REF_LENGTH));
      residue_row     = pos_diff[ROW_AW-1:0];
    end
  end

  assign residue_used = residue_aligned && ((in_ch.letter != LETTER_X) || count_x_r);
  assign write_ok     = (CALC_W'(in_ch.position) < CALC_W'(REF_LENGTH)) &&
                        (in_ch.letter < 5'(ALPHABET));

  // row memory: weights of one position plus its best weight
  assign mem_rd_en   = in_acc;
  assign mem_rd_addr = (in_ch.action == ACT_WRITE) ? ROW_AW'(in_ch.position) : residue_row;
  assign mem_wr_en   = (state_r == ST_CLEAR) || (state_r == ST_WR_STORE);
  assign mem_wr_addr = (state_r == ST_CLEAR) ? clr_row_r : wr_row_r;

  always_comb begin
    mem_wr_row            = row_r;
    mem_wr_row[BEST_SLOT] = top_r;
    if (state_r == ST_CLEAR) begin
      mem_wr_row = '0;
    end
  end

  assign mem_wr_data = mem_wr_row;
  assign mem_rd_row  = mem_rd_data;

  pmss_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (REF_LENGTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // saturating accumulation of residue weight and row best
  assign res_weight = (letter_r < 5'(ALPHABET)) ? mem_rd_row[letter_r] : '0;
  assign score_add  = {1'b0, score_r} + (SUM_W + 1)'(res_weight);
  assign best_add   = {1'b0, best_r} + (SUM_W + 1)'(mem_rd_row[BEST_SLOT]);

  // shared divider for the final percentage
  assign div_start = (state_r == ST_DIV_START);

  pmss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (prod_r),
    .denom (best_r),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_row_nxt   = clr_row_r;
    scan_nxt      = scan_r;
    count_nxt     = count_r;
    score_nxt     = score_r;
    best_nxt      = best_r;
    wr_row_nxt    = wr_row_r;
    letter_nxt    = letter_r;
    weight_nxt    = weight_r;
    use_nxt       = use_r;
    last_nxt      = last_r;
    row_nxt       = row_r;
    top_nxt       = top_r;
    prod_nxt      = prod_r;
    short_nxt     = short_r;
    zero_nxt      = zero_r;
    use_div_nxt   = use_div_r;
    pct_pre_nxt   = pct_pre_r;
    out_pct_nxt   = out_pct_r;
    out_short_nxt = out_short_r;
    out_zero_nxt  = out_zero_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;

    case (state_r)
      ST_CLEAR: begin
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == ROW_AW'(REF_LENGTH - 1)) begin
          clr_row_nxt = '0;
          state_nxt   = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.action)
            ACT_CLEAR: begin
              state_nxt = ST_CLEAR;
            end
            ACT_WRITE: begin
              wr_row_nxt = ROW_AW'(in_ch.position);
              letter_nxt = in_ch.letter;
              weight_nxt = in_ch.weight;
              if (write_ok) begin
                state_nxt = ST_WR_READ;
              end
            end
            ACT_RESIDUE: begin
              letter_nxt = in_ch.letter;
              use_nxt    = residue_used;
              last_nxt   = in_ch.last;
              if (count_r != COUNT_MAX) begin
                count_nxt = count_r + 1'b1;
              end
              state_nxt = ST_RES_ACC;
            end
            default: begin
            end
          endcase
        end
      end

      ST_WR_READ: begin
        row_nxt           = mem_rd_row;
        row_nxt[letter_r] = weight_r;
        top_nxt           = '0;
        scan_nxt          = '0;
        state_nxt         = ST_WR_SCAN;
      end

      // one letter per cycle through the comparator
      ST_WR_SCAN: begin
        if (!is_excluded(scan_r) && (row_r[scan_r] > top_r)) begin
          top_nxt = row_r[scan_r];
        end
        scan_nxt = scan_r + 1'b1;
        if (scan_r == 5'(ALPHABET - 1)) begin
          state_nxt = ST_WR_STORE;
        end
      end

      ST_WR_STORE: begin
        state_nxt = ST_IDLE;
      end

      ST_RES_ACC: begin
        if (use_r) begin
          score_nxt = score_add[SUM_W] ? SUM_MAX : score_add[SUM_W-1:0];
          best_nxt  = best_add[SUM_W] ? SUM_MAX : best_add[SUM_W-1:0];
        end
        state_nxt = last_r ? ST_FINISH : ST_IDLE;
      end

      // flags first; score at or above best saturates without dividing
      ST_FINISH: begin
        short_nxt   = extend_r &&
                      (CALC_W'(count_r) < (CALC_W'(REF_LENGTH) + CALC_W'(offset_r)));
        zero_nxt    = !short_nxt && (best_r == '0);
        prod_nxt    = NUMER_W'(score_r) * NUMER_W'(PCT_MAX);
        pct_pre_nxt = (short_nxt || zero_nxt) ? '0 : PCT_MAX;
        use_div_nxt = !short_nxt && !zero_nxt && (score_r < best_r);
        state_nxt   = use_div_nxt ? ST_DIV_START : ST_EMIT;
      end

      ST_DIV_START: begin
        state_nxt = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_pct_nxt   = use_div_r ? div_quot : pct_pre_r;
          out_short_nxt = short_r;
          out_zero_nxt  = zero_r;
          count_nxt     = '0;
          score_nxt     = '0;
          best_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_row_r   <= '0;
      scan_r      <= '0;
      count_r     <= '0;
      score_r     <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
      extend_r    <= 1'b0;
      offset_r    <= '0;
      count_x_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      scan_r      <= scan_nxt;
      count_r     <= count_nxt;
      score_r     <= score_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
      if (extend_we) begin
        extend_r <= cfg_data[0];
      end
      if (offset_we) begin
        offset_r <= cfg_data[OFFSET_W-1:0];
      end
      if (count_x_we) begin
        count_x_r <= cfg_data[0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wr_row_r    <= wr_row_nxt;
    letter_r    <= letter_nxt;
    weight_r    <= weight_nxt;
    use_r       <= use_nxt;
    last_r      <= last_nxt;
    row_r       <= row_nxt;
    top_r       <= top_nxt;
    prod_r      <= prod_nxt;
    short_r     <= short_nxt;
    zero_r      <= zero_nxt;
    use_div_r   <= use_div_nxt;
    pct_pre_r   <= pct_pre_nxt;
    out_pct_r   <= out_pct_nxt;
    out_short_r <= out_short_nxt;
    out_zero_r  <= out_zero_nxt;
  end

  // result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.percent_score = out_pct_r;
  assign out_ch.too_short     = out_short_r;
  assign out_ch.zero_best     = out_zero_r;

  // checks
  `PMSS_ASSERT_IMPL(a_pct_range, out_valid_r, out_pct_r <= PCT_MAX, "percent above saturation")
  `PMSS_ASSERT_IMPL(a_flag_zero, out_valid_r && (out_short_r || out_zero_r), (out_pct_r == '0) && !(out_short_r && out_zero_r), "flagged result with score")
  `PMSS_ASSERT_NEXT(a_emit_restart, emit_go, out_valid_r && (count_r == '0) && (score_r == '0) && (best_r == '0), "sequence not restarted after result")
  `PMSS_ASSERT_IMPL(a_div_owner, div_stat.busy, state_r == ST_DIV_WAIT, "divider busy outside its wait state")

endmodule

[verif/profile_matrix_sequence_score_core_tb.sv]
// Testbench for the weight-matrix scoring core: directed and random streams checked against a local score model
`timescale 1ns / 1ps

module profile_matrix_sequence_score_core_tb;
  import pmss_pkg::*;

  localparam int REF_LEN       = 128;
  localparam int SETTLE_CYCLES = REF_LEN + 48;  // covers a full clear in flight
  localparam int RUN_LIMIT_NS  = 10_000_000;
  localparam int FULL_SCALE    = 100 * 256;     // 100 percent in Q8

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [LETTER_W-1:0] LTR_A      = 5'd0;
  localparam logic [LETTER_W-1:0] LTR_C      = 5'd2;
  localparam logic [LETTER_W-1:0] LTR_D      = 5'd3;
  localparam logic [LETTER_W-1:0] LTR_BEYOND = 5'd31;

  // letters that never count toward a row's best weight
  localparam logic [31:0] BEST_SKIP = (32'd1 << LETTER_B) | (32'd1 << LETTER_J) |
                                      (32'd1 << LETTER_O) | (32'd1 << LETTER_U) |
                                      (32'd1 << LETTER_X) | (32'd1 << LETTER_Z);

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    position;
    logic [LETTER_W-1:0] letter;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } beat_t;

  typedef struct packed {
    logic [PCT_W-1:0] percent_score;
    logic             too_short;
    logic             zero_best;
  } score_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pmss_in_if  in_ch ();
  pmss_out_if out_ch ();

  profile_matrix_sequence_score_core #(
    .REF_LENGTH(REF_LEN)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // scoring model state
  bit [WEIGHT_W-1:0] mat_weight [REF_LEN][ALPHABET];
  bit [WEIGHT_W-1:0] row_best [REF_LEN];
  int unsigned       seq_len;
  int unsigned       seq_score;
  int unsigned       seq_best;
  bit                mode_extend;
  int unsigned       offset_cfg;
  bit                x_counted;

  beat_t       beat_queue[$];
  score_t      pending_scores[$];
  beat_t       in_flight;
  int unsigned in_wait, in_calm, out_wait, out_calm;
  int unsigned mismatches, scores_seen;
  logic [LETTER_W-1:0] hot_letters [4];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch on score %0d: %s", $time, scores_seen, what);
  endtask

  function automatic int unsigned add_capped(input int unsigned a, input int unsigned b);
    return (a + b > SUM_MAX) ? int'(SUM_MAX) : a + b;
  endfunction

  // per-beat wait, with occasional stretches of back-to-back beats
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  // expected effect of one accepted beat
  task automatic predict_score(input beat_t b);
    int unsigned     row;
    bit              hit;
    bit [WEIGHT_W-1:0] top;
    longint unsigned ratio;
    score_t          res;
    case (b.action)
      ACT_CLEAR: begin
        foreach (mat_weight[i, j]) mat_weight[i][j] = '0;
        foreach (row_best[i]) row_best[i] = '0;
      end
      ACT_WRITE: begin
        if (b.position < REF_LEN && b.letter < ALPHABET) begin
          mat_weight[b.position][b.letter] = b.weight;
          top = '0;
          for (int c = 0; c < ALPHABET; c++)
            if (!BEST_SKIP[c] && mat_weight[b.position][c] > top) top = mat_weight[b.position][c];
          row_best[b.position] = top;
        end
      end
      ACT_RESIDUE: begin
        hit = 1'b0;
        row = 0;
        if (!mode_extend) begin
          row = seq_len + offset_cfg;
          hit = row < REF_LEN;
        end else if (seq_len >= offset_cfg) begin
          row = seq_len - offset_cfg;
          hit = row < REF_LEN;
        end
        if (hit && (b.letter != LETTER_X || x_counted)) begin
          seq_score = add_capped(seq_score, (b.letter < ALPHABET) ? mat_weight[row][b.letter] : 0);
          seq_best  = add_capped(seq_best, row_best[row]);
        end
        if (seq_len < COUNT_MAX) seq_len++;
        if (b.last) begin
          res = '0;
          if (mode_extend && seq_len < REF_LEN + offset_cfg) begin
            res.too_short = 1'b1;
          end else if (seq_best == 0) begin
            res.zero_best = 1'b1;
          end else begin
            ratio = 64'(seq_score) * 64'(FULL_SCALE) / 64'(seq_best);
            res.percent_score = (ratio > PCT_MAX) ? PCT_MAX : ratio[PCT_W-1:0];
          end
          pending_scores.push_back(res);
          seq_len   = 0;
          seq_score = 0;
          seq_best  = 0;
        end
      end
      default: ;
    endcase
  endtask

  // input driver: one beat at a time from beat_queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_score(in_flight);
        in_wait = draw_wait(in_calm);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_ch.valid <= 1'b0;
        end else if (beat_queue.size() > 0) begin
          in_flight = beat_queue.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.action   <= in_flight.action;
          in_ch.position <= in_flight.position;
          in_ch.letter   <= in_flight.letter;
          in_ch.weight   <= in_flight.weight;
          in_ch.last     <= in_flight.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each score beat with the oldest prediction
  always @(posedge clk) begin : score_monitor
    score_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_scores.size() == 0) begin
          report_mismatch($sformatf("unexpected beat pct=%0d short=%0b zero=%0b",
                                    out_ch.percent_score, out_ch.too_short, out_ch.zero_best));
        end else begin
          want = pending_scores.pop_front();
          if (out_ch.percent_score !== want.percent_score)
            report_mismatch($sformatf("percent_score %0d, want %0d",
                                      out_ch.percent_score, want.percent_score));
          if (out_ch.too_short !== want.too_short)
            report_mismatch($sformatf("too_short %0b, want %0b", out_ch.too_short, want.too_short));
          if (out_ch.zero_best !== want.zero_best)
            report_mismatch($sformatf("zero_best %0b, want %0b", out_ch.zero_best, want.zero_best));
        end
        scores_seen++;
        out_wait = draw_wait(out_calm);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void push_beat(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                                    input logic [LETTER_W-1:0] ltr, input logic [WEIGHT_W-1:0] w,
                                    input logic lst);
    beat_t b;
    b.action   = act;
    b.position = pos;
    b.letter   = ltr;
    b.weight   = w;
    b.last     = lst;
    beat_queue.push_back(b);
  endfunction

  // mostly letters that the current matrix rows hold, sometimes anything up to 31
  function automatic logic [LETTER_W-1:0] pick_letter();
    if ($urandom_range(0, 3) != 0) return hot_letters[$urandom_range(0, 3)];
    return LETTER_W'($urandom_range(0, 31));
  endfunction

  function automatic void queue_weight_write(input int unsigned base);
    logic [WEIGHT_W-1:0] w;
    logic [POS_W-1:0]    pos;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      default: w = WEIGHT_W'($urandom);
    endcase
    if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom);
    else pos = POS_W'(base + $urandom_range(0, 15));
    push_beat(ACT_WRITE, pos, pick_letter(), w, 1'($urandom_range(0, 1)));
  endfunction

  // one sequence with a rare clear or unused-action beat mixed in
  function automatic void queue_sequence(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 199) == 0)
        push_beat(ACT_CLEAR, POS_W'($urandom), LETTER_W'($urandom), WEIGHT_W'($urandom), 1'b0);
      if ($urandom_range(0, 29) == 0)
        push_beat(ACT_UNUSED, POS_W'($urandom), LETTER_W'($urandom), WEIGHT_W'($urandom),
                  1'($urandom_range(0, 1)));
      push_beat(ACT_RESIDUE, POS_W'($urandom), pick_letter(), WEIGHT_W'($urandom), k == len - 1);
    end
  endfunction

  // sender holds until every queued beat is in and every score is back
  task automatic wait_idle();
    do @(negedge clk);
    while (beat_queue.size() != 0 || in_ch.valid || pending_scores.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_EXTEND_MODE:  mode_extend = val[0];
      REG_ALIGN_OFFSET: offset_cfg  = val & 32'h7F;
      REG_COUNT_X:      x_counted   = val[0];
      default: ;
    endcase
  endtask

  // reconfigure, load weights around the rows the sequences reach, then stream sequences
  task automatic run_phase(input bit ext, input int unsigned off, input bit cx,
                           input int unsigned budget, input bit long_seq);
    int unsigned used, len, base;
    wait_idle();
    write_cfg(REG_EXTEND_MODE, ext);
    write_cfg(REG_ALIGN_OFFSET, off);
    write_cfg(REG_COUNT_X, cx);
    base = ext ? 0 : off;
    hot_letters[0] = LETTER_W'($urandom_range(0, ALPHABET - 1));
    hot_letters[1] = LETTER_W'($urandom_range(0, ALPHABET - 1));
    hot_letters[2] = LETTER_X;
    hot_letters[3] = LETTER_W'($urandom_range(0, ALPHABET - 1));
    if ($urandom_range(0, 2) == 0)
      push_beat(ACT_CLEAR, POS_W'($urandom), LETTER_W'($urandom), WEIGHT_W'($urandom), 1'b0);
    for (int k = 0; k < 20; k++) queue_weight_write(base);
    used = 20;
    // extension length right at the too-short boundary
    if (long_seq) begin
      len = REF_LEN + off - 1 + $urandom_range(0, 2);
      queue_sequence(len);
      used += len;
    end
    while (used < budget) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          queue_weight_write(base);
          used++;
        end
        2: push_beat(ACT_UNUSED, POS_W'($urandom), LETTER_W'($urandom), WEIGHT_W'($urandom),
                     1'($urandom_range(0, 1)));
        default: begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          queue_sequence(len);
          used += len;
        end
      endcase
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.action   = '0;
    in_ch.position = '0;
    in_ch.letter   = '0;
    in_ch.weight   = '0;
    in_ch.last     = 1'b0;
    out_ch.ready   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: row 0 at full scale
    push_beat(ACT_WRITE, 7'd0, LTR_A, 16'hFFFF, 1'b0);
    // excluded letters do not raise the row best
    push_beat(ACT_WRITE, 7'd1, LETTER_Z, 16'hFFFF, 1'b0);
    push_beat(ACT_WRITE, 7'd1, LTR_C, 16'h0100, 1'b0);
    push_beat(ACT_WRITE, 7'd1, LETTER_B, 16'h8000, 1'b0);
    push_beat(ACT_WRITE, 7'd3, LETTER_X, 16'h4000, 1'b0);
    // last row holds only an excluded letter, so its best stays zero
    push_beat(ACT_WRITE, 7'd127, LETTER_Z, 16'h1234, 1'b0);
    // letter beyond Z: write dropped
    push_beat(ACT_WRITE, 7'd2, LTR_BEYOND, 16'hAAAA, 1'b0);
    // unused action with every field bit set
    push_beat(ACT_UNUSED, '1, '1, '1, 1'b1);
    // score above best saturates; letter beyond Z adds zero; X skipped
    push_beat(ACT_RESIDUE, '0, LTR_A, '0, 1'b0);
    push_beat(ACT_RESIDUE, '0, LETTER_Z, '0, 1'b0);
    push_beat(ACT_RESIDUE, '0, LTR_BEYOND, '0, 1'b0);
    push_beat(ACT_RESIDUE, '0, LETTER_X, '0, 1'b1);
    // clear during a sequence keeps the running sums
    push_beat(ACT_RESIDUE, '0, LTR_A, '0, 1'b0);
    push_beat(ACT_CLEAR, '0, '0, '0, 1'b0);
    push_beat(ACT_RESIDUE, '0, LTR_C, '0, 1'b1);
    // empty matrix gives zero best
    push_beat(ACT_RESIDUE, '0, LTR_D, '0, 1'b1);
    // fractional ratio: 1/3 of full scale
    push_beat(ACT_WRITE, 7'd0, LTR_D, 16'h0001, 1'b0);
    push_beat(ACT_WRITE, 7'd0, LTR_A, 16'h0003, 1'b0);
    push_beat(ACT_RESIDUE, '0, LTR_D, '0, 1'b1);

    // random phases over the register settings, extremes included
    run_phase(1'b0, 0, 1'b1, 90, 1'b0);
    run_phase(1'b0, 127, 1'b1, 50, 1'b0);
    run_phase(1'b1, 0, 1'b1, 150, 1'b1);
    run_phase(1'b0, $urandom_range(1, 126), 1'($urandom_range(0, 1)), 90, 1'b0);
    run_phase(1'b1, 127, 1'b0, 270, 1'b1);
    run_phase(1'b0, 0, 1'b0, 60, 1'b0);

    wait_idle();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/pmss_pkg.sv
rtl/pmss_chan_if.sv
rtl/pmss_ram.sv
rtl/pmss_div.sv
rtl/profile_matrix_sequence_score_core.sv
verif/profile_matrix_sequence_score_core_tb.sv
